/* hdl/hdlcd_pkg.sv */
// ----------------------------------------------------------------------------
// HDLC frame decoder package
// Shared constants, control/status bundles and the CRC-16 byte update.
// ----------------------------------------------------------------------------
package hdlcd_pkg;

  localparam int BUFFER_DEPTH_DEF = 64;

  localparam int BYTE_W    = 8;
  localparam int MAXP_W    = 7;
  localparam int FLEN_W    = 6;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CRC_W     = 16;

  localparam logic [STATUS_W-1:0] ST_OK  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_CRC = 2'd1;
  localparam logic [STATUS_W-1:0] ST_LEN = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FLAG     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PLEN = 3'd3;

  localparam logic [BYTE_W-1:0] FLAG_RST     = 8'h7E;
  localparam logic [BYTE_W-1:0] ESCAPE_RST   = 8'h7D;
  localparam logic [BYTE_W-1:0] MASK_RST     = 8'h20;
  localparam logic [MAXP_W-1:0] MAX_PLEN_RST = 7'd64;

  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

  // result kind selected for the output register
  localparam logic [1:0] SEL_LEN   = 2'd0;
  localparam logic [1:0] SEL_CRC   = 2'd1;
  localparam logic [1:0] SEL_EMPTY = 2'd2;
  localparam logic [1:0] SEL_DATA  = 2'd3;

  typedef struct packed {
    logic       capture;
    logic       open;
    logic       store;
    logic       unescape;
    logic       idx_clr;
    logic       rd_issue;
    logic       idx_inc;
    logic       out_load;
    logic [1:0] out_sel;
  } cmd_t;

  typedef struct packed {
    logic is_flag;
    logic is_esc;
    logic empty;
    logic too_short;
    logic full;
    logic crc_ok;
    logic plen_gt_max;
    logic plen_zero;
    logic idx_last;
  } sts_t;

  function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] d);
    logic [CRC_W-1:0] c;
    c = crc ^ {d, 8'h00};
    for (int b = 0; b < BYTE_W; b++) begin
      c = c[CRC_W-1] ? ({c[CRC_W-2:0], 1'b0} ^ CRC_POLY) : {c[CRC_W-2:0], 1'b0};
    end
    return c;
  endfunction

endpackage

/* hdl/hdlcd_datapath.sv */
// ----------------------------------------------------------------------------
// HDLC frame decoder datapath
// Configuration registers, payload buffer, running CRC, CRC tail bytes,
// readout index and the output register.
// ----------------------------------------------------------------------------
module hdlcd_datapath #(
  parameter int BUFFER_DEPTH = hdlcd_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [hdlcd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hdlcd_pkg::BYTE_W-1:0]      cfg_data,
  input  logic [hdlcd_pkg::BYTE_W-1:0]      rx_byte,
  input  hdlcd_pkg::cmd_t                   cmd,
  output hdlcd_pkg::sts_t                   sts,
  output logic [hdlcd_pkg::STATUS_W-1:0]    status,
  output logic                              has_data,
  output logic [hdlcd_pkg::BYTE_W-1:0]      data_byte,
  output logic [hdlcd_pkg::FLEN_W-1:0]      frame_length,
  output logic                              last
);
  import hdlcd_pkg::*;

  localparam int CW = $clog2(BUFFER_DEPTH + 1);
  localparam int AW = $clog2(BUFFER_DEPTH);

  logic [BYTE_W-1:0] flag_byte;
  logic [BYTE_W-1:0] escape_byte;
  logic [BYTE_W-1:0] escape_mask;
  logic [MAXP_W-1:0] max_payload;

  logic [BYTE_W-1:0] byte_reg;
  logic [BYTE_W-1:0] wr_data;
  logic [CW-1:0]     count;
  logic [CW-1:0]     plen;
  logic [CRC_W-1:0]  crc;
  logic [BYTE_W-1:0] tail0;
  logic [BYTE_W-1:0] tail1;
  logic [AW-1:0]     idx;
  logic [BYTE_W-1:0] rd_data;
  logic [BYTE_W-1:0] frame_store [BUFFER_DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      flag_byte   <= FLAG_RST;
      escape_byte <= ESCAPE_RST;
      escape_mask <= MASK_RST;
      max_payload <= MAX_PLEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FLAG:     flag_byte   <= cfg_data;
        CFG_ESCAPE:   escape_byte <= cfg_data;
        CFG_MASK:     escape_mask <= cfg_data;
        CFG_MAX_PLEN: max_payload <= cfg_data[MAXP_W-1:0];
        default: ;
      endcase
    end
  end

  assign wr_data = cmd.unescape ? (byte_reg ^ escape_mask) : byte_reg;
  assign plen    = count - CW'(2);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      byte_reg <= rx_byte;
    end
    if (cmd.store) begin
      frame_store[count[AW-1:0]] <= wr_data;
    end
    if (cmd.rd_issue) begin
      rd_data <= frame_store[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      crc   <= CRC_INIT;
    end else if (cmd.open) begin
      count <= '0;
      crc   <= CRC_INIT;
    end else if (cmd.store) begin
      count <= count + CW'(1);
      if (count >= CW'(2)) begin
        crc <= crc16_byte(crc, tail0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      tail0 <= tail1;
      tail1 <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + AW'(1);
    end
  end

  always_comb begin
    sts.is_flag     = (byte_reg == flag_byte);
    sts.is_esc      = (byte_reg == escape_byte);
    sts.empty       = (count == '0);
    sts.too_short   = (count < CW'(2));
    sts.full        = (count == CW'(BUFFER_DEPTH));
    sts.crc_ok      = (crc == {tail0, tail1});
    sts.plen_gt_max = (MAXP_W'(plen) > max_payload);
    sts.plen_zero   = (count == CW'(2));
    sts.idx_last    = ((CW'(idx) + CW'(1)) == plen);
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      unique case (cmd.out_sel)
        SEL_DATA: begin
          status       <= ST_OK;
          has_data     <= 1'b1;
          data_byte    <= rd_data;
          frame_length <= FLEN_W'(plen);
          last         <= sts.idx_last;
        end
        SEL_EMPTY: begin
          status       <= ST_OK;
          has_data     <= 1'b0;
          data_byte    <= '0;
          frame_length <= '0;
          last         <= 1'b1;
        end
        SEL_CRC: begin
          status       <= ST_CRC;
          has_data     <= 1'b0;
          data_byte    <= '0;
          frame_length <= '0;
          last         <= 1'b1;
        end
        default: begin
          status       <= ST_LEN;
          has_data     <= 1'b0;
          data_byte    <= '0;
          frame_length <= '0;
          last         <= 1'b1;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_store_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.store |-> (count < CW'(BUFFER_DEPTH)))
    else $error("buffer write past depth");
  a_read_in_frame: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_issue |-> (CW'(idx) < plen))
    else $error("readout past payload end");
  a_open_resets_count: assert property (@(posedge clk) disable iff (rst)
    cmd.open |=> (count == '0) && (crc == CRC_INIT))
    else $error("frame open did not reset count and crc");
`endif

endmodule

/* hdl/hdlcd_ctrl.sv */
// ----------------------------------------------------------------------------
// HDLC frame decoder controller
// Decodes each captured byte, tracks frame and escape state, and sequences
// result emission and payload readout.
// ----------------------------------------------------------------------------
module hdlcd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  hdlcd_pkg::sts_t sts,
  output hdlcd_pkg::cmd_t cmd
);
  import hdlcd_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_EMIT   = 3'd2;
  localparam logic [2:0] S_RISSUE = 3'd3;
  localparam logic [2:0] S_RLOAD  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       framing;
  logic       framing_next;
  logic       esc;
  logic       esc_next;
  logic [1:0] sel;
  logic [1:0] sel_next;
  logic       out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd          = '0;
    state_next   = state;
    framing_next = framing;
    esc_next     = esc;
    sel_next     = sel;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
        priority if (sts.is_flag) begin
          if (!framing) begin
            cmd.open     = 1'b1;
            framing_next = 1'b1;
            esc_next     = 1'b0;
          end else begin
            framing_next = 1'b0;
            priority if (sts.empty) begin
              state_next = S_IDLE;
            end else if (sts.too_short) begin
              sel_next   = SEL_LEN;
              state_next = S_EMIT;
            end else if (!sts.crc_ok) begin
              sel_next   = SEL_CRC;
              state_next = S_EMIT;
            end else if (sts.plen_gt_max) begin
              sel_next   = SEL_LEN;
              state_next = S_EMIT;
            end else if (sts.plen_zero) begin
              sel_next   = SEL_EMPTY;
              state_next = S_EMIT;
            end else begin
              cmd.idx_clr = 1'b1;
              state_next  = S_RISSUE;
            end
          end
        end else if (!framing) begin
          state_next = S_IDLE;
        end else if (sts.is_esc) begin
          esc_next = 1'b1;
        end else if (!sts.full) begin
          cmd.store    = 1'b1;
          cmd.unescape = esc;
          esc_next     = 1'b0;
        end else begin
          esc_next     = 1'b0;
          framing_next = 1'b0;
          sel_next     = SEL_LEN;
          state_next   = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = sel;
          state_next   = S_IDLE;
        end
      end
      S_RISSUE: begin
        cmd.rd_issue = 1'b1;
        state_next   = S_RLOAD;
      end
      S_RLOAD: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = SEL_DATA;
          cmd.idx_inc  = 1'b1;
          state_next   = sts.idx_last ? S_IDLE : S_RISSUE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      framing   <= 1'b0;
      esc       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      framing <= framing_next;
      esc     <= esc_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    sel <= sel_next;
  end

`ifndef NO_ASSERTIONS
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> out_free)
    else $error("output register overwritten");
  a_store_inside: assert property (@(posedge clk) disable iff (rst)
    cmd.store |-> framing && !sts.full && !sts.is_flag)
    else $error("store outside a frame");
  a_open_clears_esc: assert property (@(posedge clk) disable iff (rst)
    cmd.open |=> framing && !esc)
    else $error("frame open left escape pending");
`endif

endmodule

/* hdl/hdlc_frame_decoder_crc16_unit.sv */
// ----------------------------------------------------------------------------
// HDLC frame decoder with CRC-16 check
// An input byte is captured, then decoded in the controller.
// Single results (errors, empty frame) are loaded in the emit state after
// decode. A good frame is read out of the payload buffer byte by byte (one
// buffer read, one output load); each output load waits out any output stall.
// Reset clears frame state and restores default delimiter, escape, mask and
// length limit; the payload buffer is not cleared.
// ----------------------------------------------------------------------------
module hdlc_frame_decoder_crc16_unit #(
  parameter int BUFFER_DEPTH = hdlcd_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [hdlcd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hdlcd_pkg::BYTE_W-1:0]      cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [hdlcd_pkg::BYTE_W-1:0]      rx_byte,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [hdlcd_pkg::STATUS_W-1:0]    status,
  output logic                              has_data,
  output logic [hdlcd_pkg::BYTE_W-1:0]      data_byte,
  output logic [hdlcd_pkg::FLEN_W-1:0]      frame_length,
  output logic                              last
);
  import hdlcd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  hdlcd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  hdlcd_datapath #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .rx_byte      (rx_byte),
    .cmd          (cmd),
    .sts          (sts),
    .status       (status),
    .has_data     (has_data),
    .data_byte    (data_byte),
    .frame_length (frame_length),
    .last         (last)
  );

endmodule
